FILE: hw/rtl/ssbr_pkg.sv
// ----------------------------------------------------------------------------
// ssbr_pkg
// Shared types, codes and lookup functions for the seven segment display,
// relay and light measurement register device.
// ----------------------------------------------------------------------------
package ssbr_pkg;

    localparam int SAMPLES_PER_MEASURE_DEF = 8;
    localparam int CFG_W  = 10;
    localparam int SUM_W  = 13;
    localparam int SMP_W  = 10;

    // Transaction kinds on the input channel.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_BUS  = 2'd1;
    localparam logic [1:0] CMD_ADC  = 2'd2;

    // Bus command codes.
    localparam logic [7:0] BUS_RELAYS  = 8'h01;
    localparam logic [7:0] BUS_DIGIT   = 8'h02;
    localparam logic [7:0] BUS_RATE    = 8'h03;
    localparam logic [7:0] BUS_INT_LO  = 8'h04;
    localparam logic [7:0] BUS_INT_HI  = 8'h05;
    localparam logic [7:0] BUS_READ    = 8'h20;

    // Read-back addresses.
    localparam logic [7:0] RD_RELAYS   = 8'd1;
    localparam logic [7:0] RD_DIGIT    = 8'd2;
    localparam logic [7:0] RD_RATE     = 8'd3;
    localparam logic [7:0] RD_INT_LO   = 8'd4;
    localparam logic [7:0] RD_INT_HI   = 8'd5;
    localparam logic [7:0] RD_LIGHT_LO = 8'd6;
    localparam logic [7:0] RD_LIGHT_HI = 8'd7;
    localparam logic [7:0] RD_UNKNOWN  = 8'hff;

    // Configuration register indexes.
    localparam logic CFG_CURRENT_ON    = 1'b0;
    localparam logic CFG_MEASURE_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] CURRENT_ON_RST    = 10'd200;
    localparam logic [CFG_W-1:0] MEASURE_PERIOD_RST = 10'd1000;

    // Integer show sequence steps.
    localparam logic [3:0] SEQ_IDLE    = 4'd0;
    localparam logic [3:0] SEQ_SAVE    = 4'd1;
    localparam logic [3:0] SEQ_THOU    = 4'd2;
    localparam logic [3:0] SEQ_GAP_1   = 4'd3;
    localparam logic [3:0] SEQ_HUND    = 4'd4;
    localparam logic [3:0] SEQ_GAP_2   = 4'd5;
    localparam logic [3:0] SEQ_TENS    = 4'd6;
    localparam logic [3:0] SEQ_GAP_3   = 4'd7;
    localparam logic [3:0] SEQ_UNITS   = 4'd8;
    localparam logic [3:0] SEQ_RESTORE = 4'd9;

    localparam logic [15:0] SHOW_LIMIT     = 16'd10000;
    localparam logic [15:0] LIGHT_UNLATCHED = 16'hffff;
    localparam logic [6:0]  SEG_ZERO       = 7'h7e;
    localparam logic [3:0]  RATE_MAX       = 4'd10;
    localparam logic [3:0]  RATE_SHOW      = 4'd1;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       code;
        logic [7:0]       value;
        logic [SMP_W-1:0] adc_sample;
        logic             high_current;
    } ssbr_in_t;

    typedef struct packed {
        logic [6:0] segments;
        logic [1:0] relays;
        logic       current_enable;
        logic       adc_running;
        logic       read_valid;
        logic [7:0] read_data;
    } ssbr_out_t;

    typedef enum logic [1:0] {
        SMP_IDLE,
        SMP_DISCARD,
        SMP_COLLECT
    } smp_state_t;

    typedef struct packed {
        logic start;
        logic sample;
    } smp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } smp_stat_t;

    function automatic logic [6:0] digit_pattern(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'h7e;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h6d;
            4'd3:    p = 7'h4f;
            4'd4:    p = 7'h17;
            4'd5:    p = 7'h5b;
            4'd6:    p = 7'h7b;
            4'd7:    p = 7'h0e;
            4'd8:    p = 7'h7f;
            4'd9:    p = 7'h5f;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    // Half period of the blink in milliseconds for a rate in Hz.
    function automatic logic [9:0] half_period(input logic [3:0] f);
        logic [9:0] h;
        case (f)
            4'd1:    h = 10'd500;
            4'd2:    h = 10'd250;
            4'd3:    h = 10'd167;
            4'd4:    h = 10'd125;
            4'd5:    h = 10'd100;
            4'd6:    h = 10'd83;
            4'd7:    h = 10'd71;
            4'd8:    h = 10'd63;
            4'd9:    h = 10'd56;
            4'd10:   h = 10'd50;
            default: h = 10'd0;
        endcase
        return h;
    endfunction

    // Leading decimal digit of v for a place value of unit, with v below ten units.
    // Nine independent compares against the multiples of the unit.
    function automatic logic [3:0] div_digit(input logic [13:0] v, input logic [13:0] unit);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (int'(v) >= k * int'(unit)) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

endpackage

FILE: hw/rtl/ssbr_sampler.sv
// ----------------------------------------------------------------------------
// ssbr_sampler
// Light measurement sampler: drops the first conversion after a start, then
// sums a fixed number of samples with saturation and holds the result.
// ----------------------------------------------------------------------------
module ssbr_sampler #(
    parameter int SAMPLES_PER_MEASURE = ssbr_pkg::SAMPLES_PER_MEASURE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssbr_pkg::smp_ctrl_t         ctrl,
    input  logic [ssbr_pkg::SMP_W-1:0]  sample,
    output ssbr_pkg::smp_stat_t         stat,
    output logic [ssbr_pkg::SUM_W-1:0]  light_value
);

    localparam int IDX_W = (SAMPLES_PER_MEASURE > 1) ? $clog2(SAMPLES_PER_MEASURE) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_MEASURE - 1);
    localparam int SUM_W = ssbr_pkg::SUM_W;

    ssbr_pkg::smp_state_t state_reg, state_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] light_reg, light_next;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat;
    logic             last;

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sample);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign last    = (index_reg == IDX_LAST);

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.start)
        begin
            state_next = ssbr_pkg::SMP_DISCARD;
        end
        else if (ctrl.sample)
        begin
            case (state_reg)
                ssbr_pkg::SMP_DISCARD: state_next = ssbr_pkg::SMP_COLLECT;
                ssbr_pkg::SMP_COLLECT:
                begin
                    if (last)
                    begin
                        state_next = ssbr_pkg::SMP_IDLE;
                    end
                end
                default: state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        index_next = index_reg;
        sum_next   = sum_reg;
        light_next = light_reg;
        stat.busy  = (state_reg != ssbr_pkg::SMP_IDLE);
        stat.done  = 1'b0;
        if (ctrl.start)
        begin
            index_next = '0;
            sum_next   = '0;
        end
        else if (ctrl.sample)
        begin
            case (state_reg)
                ssbr_pkg::SMP_DISCARD:
                begin
                    index_next = '0;
                    sum_next   = '0;
                end
                ssbr_pkg::SMP_COLLECT:
                begin
                    sum_next = sum_sat;
                    if (last)
                    begin
                        index_next = '0;
                        light_next = sum_sat;
                        stat.done  = 1'b1;
                    end
                    else
                    begin
                        index_next = index_reg + IDX_W'(1);
                    end
                end
                default: index_next = index_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssbr_pkg::SMP_IDLE;
            index_reg <= '0;
            sum_reg   <= '0;
            light_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            index_reg <= index_next;
            sum_reg   <= sum_next;
            light_reg <= light_next;
        end
    end

    assign light_value = light_reg;

endmodule

FILE: hw/rtl/seven_segment_blink_register_device_top.sv
// ----------------------------------------------------------------------------
// seven_segment_blink_register_device_top
// Display, relay and light measurement register device: millisecond ticks,
// two-byte bus commands and ADC conversions in, one status result out each.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. An item is
// held in an input register and is worked from there into the result
// register, where its result is offered. A new item is taken every clock
// as long as results are taken. A waiting result does not block the input
// register, so one more item can be taken while the output stalls.
// Configuration writes are meant for when no transaction is in flight.
module seven_segment_blink_register_device_top #(
    parameter int SAMPLES_PER_MEASURE = ssbr_pkg::SAMPLES_PER_MEASURE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ssbr_pkg::ssbr_in_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ssbr_pkg::ssbr_out_t         out_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ssbr_pkg::CFG_W-1:0]  cfg_data
);

    localparam int CFG_W = ssbr_pkg::CFG_W;
    localparam int SUM_W = ssbr_pkg::SUM_W;

    // Handshake and pipeline registers
    logic                in_full_reg, in_full_next;
    ssbr_pkg::ssbr_in_t  in_item_reg;
    logic                out_full_reg, out_full_next;
    ssbr_pkg::ssbr_out_t out_item_reg, out_item_next;
    logic                in_take, advance;

    // Configuration
    logic [CFG_W-1:0] cur_on_reg, period_len_reg;

    // Display state
    logic [9:0]  blink_ticks_reg, blink_ticks_next;
    logic [9:0]  blink_reload_reg, blink_reload_next;
    logic [9:0]  saved_reload_reg, saved_reload_next;
    logic [3:0]  blink_rate_reg, blink_rate_next;
    logic [3:0]  shown_digit_reg, shown_digit_next;
    logic [3:0]  saved_digit_reg, saved_digit_next;
    logic [3:0]  seq_step_reg, seq_step_next;
    logic [13:0] shown_int_reg, shown_int_next;
    logic [15:0] pending_int_reg, pending_int_next;
    logic [9:0]  digit_rem_reg, digit_rem_next;
    logic [6:0]  seg_reg, seg_next;
    logic [1:0]  relay_reg, relay_next;

    // Measurement state
    logic [9:0]  period_ticks_reg, period_ticks_next;
    logic        current_flag_reg, current_flag_next;
    logic        adc_flag_reg, adc_flag_next;
    logic [15:0] light_latched_reg, light_latched_next;

    ssbr_pkg::smp_ctrl_t smp_ctrl;
    ssbr_pkg::smp_stat_t smp_stat;
    logic [SUM_W-1:0]    light_value;

    logic       read_valid;
    logic [7:0] read_data;
    logic       meas_start;

    assign in_stall = in_full_reg && out_full_reg && out_stall;
    assign in_take  = in_valid && !in_stall;
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);

    assign in_full_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_full_reg);
    assign out_full_next = advance ? 1'b1 : (out_full_reg && out_stall);

    assign smp_ctrl.start  = meas_start;
    assign smp_ctrl.sample = advance && (in_item_reg.command == ssbr_pkg::CMD_ADC);

    ssbr_sampler #(
        .SAMPLES_PER_MEASURE (SAMPLES_PER_MEASURE)
    ) u_sampler (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (smp_ctrl),
        .sample      (in_item_reg.adc_sample),
        .stat        (smp_stat),
        .light_value (light_value)
    );

    always_comb
    begin
        logic [9:0]  bt_inc;
        logic [9:0]  pt_inc;
        logic [3:0]  dig;
        logic [15:0] pend_sum;

        bt_inc   = blink_ticks_reg + 10'd1;
        pt_inc   = period_ticks_reg + 10'd1;
        dig      = 4'd0;
        pend_sum = pending_int_reg + {in_item_reg.value, 8'h00};

        blink_ticks_next   = blink_ticks_reg;
        blink_reload_next  = blink_reload_reg;
        saved_reload_next  = saved_reload_reg;
        blink_rate_next    = blink_rate_reg;
        shown_digit_next   = shown_digit_reg;
        saved_digit_next   = saved_digit_reg;
        seq_step_next      = seq_step_reg;
        shown_int_next     = shown_int_reg;
        pending_int_next   = pending_int_reg;
        digit_rem_next     = digit_rem_reg;
        seg_next           = seg_reg;
        relay_next         = relay_reg;
        period_ticks_next  = period_ticks_reg;
        current_flag_next  = current_flag_reg;
        adc_flag_next      = adc_flag_reg;
        light_latched_next = light_latched_reg;
        read_valid         = 1'b0;
        read_data          = 8'h00;
        meas_start         = 1'b0;

        if (advance)
        begin
            case (in_item_reg.command)
                ssbr_pkg::CMD_TICK:
                begin
                    // Display blink and integer show sequencer
                    if (blink_reload_reg == 10'd0)
                    begin
                        blink_ticks_next = 10'd0;
                        seg_next = ssbr_pkg::digit_pattern(shown_digit_reg);
                    end
                    else if (bt_inc < blink_reload_reg)
                    begin
                        blink_ticks_next = bt_inc;
                    end
                    else
                    begin
                        blink_ticks_next = 10'd0;
                        case (seq_step_reg)
                            ssbr_pkg::SEQ_SAVE:
                            begin
                                saved_digit_next = shown_digit_reg;
                                seq_step_next    = ssbr_pkg::SEQ_THOU;
                                seg_next         = '0;
                            end
                            ssbr_pkg::SEQ_THOU:
                            begin
                                dig = ssbr_pkg::div_digit(shown_int_reg, 14'd1000);
                                digit_rem_next = 10'(int'(shown_int_reg) - int'(dig) * 1000);
                                seq_step_next    = ssbr_pkg::SEQ_GAP_1;
                                seg_next         = ssbr_pkg::digit_pattern(dig);
                                shown_digit_next = dig;
                            end
                            ssbr_pkg::SEQ_HUND:
                            begin
                                dig = ssbr_pkg::div_digit(14'(digit_rem_reg), 14'd100);
                                digit_rem_next = 10'(int'(digit_rem_reg) - int'(dig) * 100);
                                seq_step_next    = ssbr_pkg::SEQ_GAP_2;
                                seg_next         = ssbr_pkg::digit_pattern(dig);
                                shown_digit_next = dig;
                            end
                            ssbr_pkg::SEQ_TENS:
                            begin
                                dig = ssbr_pkg::div_digit(14'(digit_rem_reg), 14'd10);
                                digit_rem_next = 10'(int'(digit_rem_reg) - int'(dig) * 10);
                                seq_step_next    = ssbr_pkg::SEQ_GAP_3;
                                seg_next         = ssbr_pkg::digit_pattern(dig);
                                shown_digit_next = dig;
                            end
                            ssbr_pkg::SEQ_UNITS:
                            begin
                                dig              = digit_rem_reg[3:0];
                                seq_step_next    = ssbr_pkg::SEQ_RESTORE;
                                seg_next         = ssbr_pkg::digit_pattern(dig);
                                shown_digit_next = dig;
                            end
                            ssbr_pkg::SEQ_GAP_1,
                            ssbr_pkg::SEQ_GAP_2,
                            ssbr_pkg::SEQ_GAP_3:
                            begin
                                seq_step_next = seq_step_reg + 4'd1;
                                seg_next      = '0;
                            end
                            ssbr_pkg::SEQ_RESTORE:
                            begin
                                seq_step_next     = ssbr_pkg::SEQ_IDLE;
                                seg_next          = '0;
                                blink_reload_next = saved_reload_reg;
                                shown_digit_next  = saved_digit_reg;
                            end
                            default:
                            begin
                                if (seg_reg != 7'h00)
                                begin
                                    seg_next = '0;
                                end
                                else
                                begin
                                    seg_next = ssbr_pkg::digit_pattern(shown_digit_reg);
                                end
                            end
                        endcase
                    end

                    // Current duty cycle and measurement start
                    period_ticks_next = pt_inc;
                    if (pt_inc < cur_on_reg)
                    begin
                        current_flag_next = 1'b1;
                    end
                    else if (pt_inc == cur_on_reg)
                    begin
                        if (!in_item_reg.high_current)
                        begin
                            meas_start    = 1'b1;
                            adc_flag_next = 1'b1;
                        end
                        else
                        begin
                            current_flag_next = 1'b0;
                        end
                    end
                    else if (pt_inc >= period_len_reg)
                    begin
                        period_ticks_next = 10'd0;
                    end
                end
                ssbr_pkg::CMD_ADC:
                begin
                    if (smp_stat.done)
                    begin
                        adc_flag_next     = 1'b0;
                        current_flag_next = 1'b0;
                    end
                end
                ssbr_pkg::CMD_BUS:
                begin
                    case (in_item_reg.code)
                        ssbr_pkg::BUS_RELAYS: relay_next = in_item_reg.value[1:0];
                        ssbr_pkg::BUS_DIGIT:
                        begin
                            if (in_item_reg.value < 8'd10)
                            begin
                                seg_next = ssbr_pkg::digit_pattern(in_item_reg.value[3:0]);
                                shown_digit_next = in_item_reg.value[3:0];
                            end
                        end
                        ssbr_pkg::BUS_RATE:
                        begin
                            if (in_item_reg.value <= 8'(ssbr_pkg::RATE_MAX) &&
                                seq_step_reg == ssbr_pkg::SEQ_IDLE)
                            begin
                                blink_reload_next =
                                    ssbr_pkg::half_period(in_item_reg.value[3:0]);
                                blink_rate_next = in_item_reg.value[3:0];
                            end
                        end
                        ssbr_pkg::BUS_INT_LO: pending_int_next = 16'(in_item_reg.value);
                        ssbr_pkg::BUS_INT_HI:
                        begin
                            pending_int_next = pend_sum;
                            if (pend_sum < ssbr_pkg::SHOW_LIMIT)
                            begin
                                shown_int_next    = pend_sum[13:0];
                                saved_reload_next = blink_reload_reg;
                                blink_ticks_next  = 10'd0;
                                // A restart keeps the running 1 Hz settings.
                                if (seq_step_reg == ssbr_pkg::SEQ_IDLE)
                                begin
                                    blink_reload_next = ssbr_pkg::half_period(ssbr_pkg::RATE_SHOW);
                                    blink_rate_next   = ssbr_pkg::RATE_SHOW;
                                end
                                seq_step_next = ssbr_pkg::SEQ_SAVE;
                            end
                        end
                        ssbr_pkg::BUS_READ:
                        begin
                            read_valid = 1'b1;
                            case (in_item_reg.value)
                                ssbr_pkg::RD_RELAYS: read_data = 8'(relay_reg);
                                ssbr_pkg::RD_DIGIT:  read_data = 8'(shown_digit_reg);
                                ssbr_pkg::RD_RATE:   read_data = 8'(blink_rate_reg);
                                ssbr_pkg::RD_INT_LO: read_data = shown_int_reg[7:0];
                                ssbr_pkg::RD_INT_HI: read_data = 8'(shown_int_reg[13:8]);
                                ssbr_pkg::RD_LIGHT_LO:
                                begin
                                    // The low byte read latches the sum for a consistent pair.
                                    if (light_latched_reg == ssbr_pkg::LIGHT_UNLATCHED)
                                    begin
                                        light_latched_next = 16'(light_value);
                                        read_data = light_value[7:0];
                                    end
                                    else
                                    begin
                                        read_data = light_latched_reg[7:0];
                                    end
                                end
                                ssbr_pkg::RD_LIGHT_HI:
                                begin
                                    read_data          = light_latched_reg[15:8];
                                    light_latched_next = ssbr_pkg::LIGHT_UNLATCHED;
                                end
                                default: read_data = ssbr_pkg::RD_UNKNOWN;
                            endcase
                        end
                        default: relay_next = relay_reg;
                    endcase
                end
                default: relay_next = relay_reg;
            endcase
        end

        out_item_next.segments       = seg_next;
        out_item_next.relays         = relay_next;
        out_item_next.current_enable = current_flag_next;
        out_item_next.adc_running    = adc_flag_next;
        out_item_next.read_valid     = read_valid;
        out_item_next.read_data      = read_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg       <= 1'b0;
            out_full_reg      <= 1'b0;
            cur_on_reg        <= ssbr_pkg::CURRENT_ON_RST;
            period_len_reg    <= ssbr_pkg::MEASURE_PERIOD_RST;
            blink_ticks_reg   <= '0;
            blink_reload_reg  <= '0;
            saved_reload_reg  <= '0;
            blink_rate_reg    <= '0;
            shown_digit_reg   <= '0;
            saved_digit_reg   <= '0;
            seq_step_reg      <= ssbr_pkg::SEQ_IDLE;
            shown_int_reg     <= '0;
            pending_int_reg   <= '0;
            seg_reg           <= ssbr_pkg::SEG_ZERO;
            relay_reg         <= '0;
            period_ticks_reg  <= '0;
            current_flag_reg  <= 1'b0;
            adc_flag_reg      <= 1'b0;
            light_latched_reg <= ssbr_pkg::LIGHT_UNLATCHED;
        end
        else
        begin
            in_full_reg       <= in_full_next;
            out_full_reg      <= out_full_next;
            blink_ticks_reg   <= blink_ticks_next;
            blink_reload_reg  <= blink_reload_next;
            saved_reload_reg  <= saved_reload_next;
            blink_rate_reg    <= blink_rate_next;
            shown_digit_reg   <= shown_digit_next;
            saved_digit_reg   <= saved_digit_next;
            seq_step_reg      <= seq_step_next;
            shown_int_reg     <= shown_int_next;
            pending_int_reg   <= pending_int_next;
            seg_reg           <= seg_next;
            relay_reg         <= relay_next;
            period_ticks_reg  <= period_ticks_next;
            current_flag_reg  <= current_flag_next;
            adc_flag_reg      <= adc_flag_next;
            light_latched_reg <= light_latched_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ssbr_pkg::CFG_CURRENT_ON:     cur_on_reg     <= cfg_data;
                    ssbr_pkg::CFG_MEASURE_PERIOD: period_len_reg <= cfg_data;
                    default:                      cur_on_reg     <= cur_on_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg   <= out_item_next;
            digit_rem_reg  <= digit_rem_next;
        end
    end

    assign out_valid = out_full_reg;
    assign out_data  = out_item_reg;

    // The running flag follows the sampler exactly: set at start, cleared at done.
    assert property (@(posedge clk) disable iff (!rst_n)
        adc_flag_reg == smp_stat.busy)
        else $error("adc_running out of step with the sampler");

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_step_reg <= ssbr_pkg::SEQ_RESTORE)
        else $error("show sequencer left its step range");

    assert property (@(posedge clk) disable iff (!rst_n)
        16'(shown_int_reg) < ssbr_pkg::SHOW_LIMIT && shown_digit_reg < 4'd10)
        else $error("shown integer or digit out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_full_reg) |-> $past(in_full_reg))
        else $error("result produced without a held input item");

endmodule
